@@ src/bfa_pkg.sv @@
// ----------------------------------------------------------------------------
// bfa_pkg
// Shared types and constants for the best-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package bfa_pkg;
  localparam int unsigned MaxEntriesDef = 128;
  localparam int unsigned AlignBytesDef = 4;

  typedef enum logic [2:0] {
    StOk       = 3'd0,
    StSizeFull = 3'd1,
    StNoFit    = 3'd2,
    StType     = 3'd3,
    StNotFound = 3'd4
  } status_e;

  typedef enum logic [0:0] {
    OpAlloc = 1'b0,
    OpFree  = 1'b1
  } op_e;

  localparam logic [1:0] CfgBase  = 2'd0;
  localparam logic [1:0] CfgBytes = 2'd1;
  localparam logic [1:0] CfgType  = 2'd2;

  typedef enum logic [2:0] {
    SIdle, SScanRd, SScan, SShiftRd, SShiftWr, SOut
  } state_e;
endpackage
`default_nettype wire

@@ src/best_fit_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// best_fit_block_allocator_unit
// Best-fit allocator keeping a sorted table of blocks in on-chip memory.
// ----------------------------------------------------------------------------
// Usage: items enter on in_valid_i/in_stall_o with op_i, request_bytes_i,
// type_mask_i and free_address_i. Each item gives one result on out_valid_o
// with block_address_o and status_o, held while out_stall_i is high.
// Registers region_base, region_bytes, pool_type are written through
// cfg_valid_i/cfg_ready_o with cfg_index_i and cfg_data_i; ready is high only
// while idle with no input valid. ALIGN_BYTES is a power of two.
// One item at a time. An allocate scans all N+1 gaps, one table entry read
// per cycle, then shifts the table up by one entry from the chosen slot, with
// a read state and a write state per entry; a free scans for the address and
// shifts the tail down likewise. Reset clears the entry count; table contents
// are not cleared. A stalled result holds the block busy until it transfers.
// ----------------------------------------------------------------------------
`default_nettype none
module best_fit_block_allocator_unit #(
  parameter int unsigned MAX_ENTRIES = bfa_pkg::MaxEntriesDef,
  parameter int unsigned ALIGN_BYTES = bfa_pkg::AlignBytesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        op_i,
  input  logic [31:0] request_bytes_i,
  input  logic [31:0] type_mask_i,
  input  logic [31:0] free_address_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] block_address_o,
  output logic [2:0]  status_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);
  import bfa_pkg::*;
  localparam int unsigned IW = $clog2(MAX_ENTRIES);
  localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned AL = $clog2(ALIGN_BYTES);

  logic [63:0] mem [MAX_ENTRIES];
  logic [63:0] rd_q;
  logic [IW-1:0] ra, wa;
  logic          we;
  logic [63:0]   wd;

  always_ff @(posedge clk_i) begin
    if (we) mem[wa] <= wd;
    rd_q <= mem[ra];
  end

  state_e st_q, st_d;
  logic [31:0] base_q, bytes_q, ptype_q;
  logic [CW-1:0] cnt_q, cnt_d, i_q, i_d, bi_q, bi_d;
  logic op_q, op_d, found_q, found_d;
  logic [32:0] size_q, size_d, prev_q, prev_d, bgap_q, bgap_d;
  logic [31:0] addr_q, addr_d, res_q, res_d;
  logic [2:0]  stat_q, stat_d;

  assign cfg_ready_o = (st_q == SIdle) && !in_valid_i;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= '0; bytes_q <= '0; ptype_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CfgBase:  base_q  <= cfg_data_i;
        CfgBytes: bytes_q <= cfg_data_i;
        CfgType:  ptype_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [32:0] rend, pend, nstart, gap;
  logic [33:0] rsum, asz;
  always_comb begin
    rsum = {2'b0, base_q} + {2'b0, bytes_q};
    rend = rsum[33:32] != 2'b0 ? 33'h1_0000_0000 : rsum[32:0];
    nstart = (i_q < cnt_q) ? {1'b0, rd_q[63:32]} : rend;
    gap = (nstart > prev_q) ? nstart - prev_q : '0;
    pend = {1'b0, rd_q[63:32]} + {1'b0, rd_q[31:0]};
    asz = (({2'b0, request_bytes_i} + 34'(ALIGN_BYTES - 1)) >> AL) << AL;
  end

  assign in_stall_o      = (st_q != SIdle);
  assign out_valid_o     = (st_q == SOut);
  assign block_address_o = res_q;
  assign status_o        = stat_q;

  always_comb begin
    st_d = st_q; cnt_d = cnt_q; i_d = i_q; bi_d = bi_q; op_d = op_q;
    found_d = found_q; size_d = size_q; prev_d = prev_q; bgap_d = bgap_q;
    addr_d = addr_q; res_d = res_q; stat_d = stat_q;
    ra = i_q[IW-1:0]; wa = i_q[IW-1:0]; we = 1'b0; wd = '0;
    case (st_q)
      SIdle: if (in_valid_i) begin
        op_d = op_i; addr_d = free_address_i; res_d = '0; i_d = '0;
        found_d = 1'b0; prev_d = {1'b0, base_q}; bgap_d = '0;
        size_d = asz[33] ? '1 : asz[32:0];
        if (op_i == OpFree[0]) begin
          if (cnt_q == '0) begin stat_d = StNotFound; st_d = SOut; end
          else st_d = SScanRd;
        end else if ((ptype_q & type_mask_i) == '0) begin
          stat_d = StType; st_d = SOut;
        end else if (request_bytes_i == '0 || cnt_q >= CW'(MAX_ENTRIES)) begin
          stat_d = StSizeFull; st_d = SOut;
        end else st_d = SScanRd;
      end
      SScanRd: st_d = SScan;
      SScan: begin
        if (op_q == OpFree[0]) begin
          if (rd_q[63:32] == addr_q) begin
            stat_d = StOk; cnt_d = cnt_q - 1'b1; bi_d = i_q;
            if (i_q + 1'b1 < cnt_q) begin i_d = i_q + 1'b1; st_d = SShiftRd; end
            else st_d = SOut;
          end else if (i_q + 1'b1 >= cnt_q) begin
            stat_d = StNotFound; st_d = SOut;
          end else begin i_d = i_q + 1'b1; ra = IW'(i_q + 1'b1); end
        end else begin
          if (size_q <= gap && (!found_q || gap < bgap_q)) begin
            found_d = 1'b1; bi_d = i_q; res_d = prev_q[31:0]; bgap_d = gap;
          end
          prev_d = pend;
          if (i_q == cnt_q) begin
            if (!(found_q || (size_q <= gap))) begin stat_d = StNoFit; st_d = SOut; end
            else begin
              stat_d = StOk;
              i_d = cnt_q; st_d = SShiftRd;
            end
          end else begin i_d = i_q + 1'b1; ra = IW'(i_q + 1'b1); end
        end
      end
      SShiftRd: begin
        if (op_q == OpFree[0]) ra = i_q[IW-1:0];
        else if (i_q == bi_q) begin
          we = 1'b1; wa = bi_q[IW-1:0];
          wd = {res_q, size_q[31:0]}; cnt_d = cnt_q + 1'b1; st_d = SOut;
        end else ra = IW'(i_q - 1'b1);
        if (!(op_q == OpAlloc[0] && i_q == bi_q)) st_d = SShiftWr;
      end
      SShiftWr: begin
        we = 1'b1; wd = rd_q;
        if (op_q == OpFree[0]) begin
          wa = IW'(i_q - 1'b1);
          if (i_q + 1'b1 > cnt_q) st_d = SOut;
          else begin i_d = i_q + 1'b1; st_d = SShiftRd; end
        end else begin
          wa = i_q[IW-1:0]; i_d = i_q - 1'b1; st_d = SShiftRd;
        end
      end
      SOut: begin
        if (stat_q != StOk) res_d = '0;
        if (!out_stall_i) st_d = SIdle;
      end
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; cnt_q <= '0;
    end else begin
      st_q <= st_d; cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d; bi_q <= bi_d; op_q <= op_d; found_q <= found_d;
    size_q <= size_d; prev_q <= prev_d; bgap_q <= bgap_d; addr_q <= addr_d;
    res_q <= res_d; stat_q <= stat_d;
  end
endmodule
`default_nettype wire

@@ src/bfa_checker.sv @@
// ----------------------------------------------------------------------------
// bfa_checker
// Port-level checks for the best-fit block allocator.
// ----------------------------------------------------------------------------
`default_nettype none
module bfa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] block_address_o,
  input logic [2:0]  status_o
);
  import bfa_pkg::*;
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o) else $error("accept while result pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o))
    else $error("result dropped");
  a_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != StOk |-> block_address_o == '0)
    else $error("nonzero address on failure");
  a_stat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> status_o <= StNotFound) else $error("bad status");
endmodule
bind best_fit_block_allocator_unit bfa_checker u_bfa_checker (.*);
`default_nettype wire

@@ dv/tb_best_fit_block_allocator_unit.sv @@
// ----------------------------------------------------------------------------
// tb_best_fit_block_allocator_unit
// Self-checking bench for the best-fit allocator: random alloc/free traffic
// over several region settings, predicted by a table model of its own.
// ----------------------------------------------------------------------------
`default_nettype none

class alloc_scoreboard;
  logic [31:0] starts[$];
  logic [31:0] sizes[$];
  logic [31:0] base, bytes, ptype;
  logic [31:0] exp_addr[$];
  logic [2:0]  exp_st[$];
  int          errors;

  function new();
    base = 0; bytes = 0; ptype = 0; errors = 0;
  endfunction

  function void write_reg(logic [1:0] idx, logic [31:0] v);
    if (idx == bfa_pkg::CfgBase) base = v;
    else if (idx == bfa_pkg::CfgBytes) bytes = v;
    else if (idx == bfa_pkg::CfgType) ptype = v;
  endfunction

  function void note_item(logic op, logic [31:0] req, logic [31:0] mask, logic [31:0] fa);
    logic [33:0] rend, size, prev_end, next_start, gap, best_gap, best_start;
    int fit_pos, n;
    bit found, hit;
    logic [31:0] addr;
    logic [2:0] st;
    addr = 0; st = bfa_pkg::StOk; found = 0; fit_pos = 0; best_gap = 0;
    best_start = 0; hit = 0;
    n = starts.size();
    if (op == bfa_pkg::OpFree) begin
      st = bfa_pkg::StNotFound;
      for (int i = 0; i < n; i++) begin
        if (!hit && starts[i] == fa) begin
          hit = 1;
          starts.delete(i); sizes.delete(i);
          st = bfa_pkg::StOk;
        end
      end
    end else if ((ptype & mask) == 0) begin
      st = bfa_pkg::StType;
    end else if (req == 0 || n >= bfa_pkg::MaxEntriesDef) begin
      st = bfa_pkg::StSizeFull;
    end else begin
      rend = {2'b0, base} + {2'b0, bytes};
      if (rend > 34'h100000000) rend = 34'h100000000;
      size = (({2'b0, req} + 3) >> 2) << 2;
      for (int i = 0; i <= n; i++) begin
        prev_end = (i > 0) ? {2'b0, starts[i-1]} + {2'b0, sizes[i-1]} : {2'b0, base};
        next_start = (i < n) ? {2'b0, starts[i]} : rend;
        gap = (next_start > prev_end) ? next_start - prev_end : 0;
        if (size <= gap && (!found || gap < best_gap)) begin
          found = 1; fit_pos = i; best_start = prev_end; best_gap = gap;
        end
      end
      if (!found) st = bfa_pkg::StNoFit;
      else begin
        starts.insert(fit_pos, best_start[31:0]);
        sizes.insert(fit_pos, size[31:0]);
        addr = best_start[31:0];
      end
    end
    exp_addr.push_back(addr);
    exp_st.push_back(st);
  endfunction

  function void check_result(logic [31:0] addr, logic [2:0] st);
    logic [31:0] ea;
    logic [2:0] es;
    if (exp_st.size() == 0) begin
      $display("%0t: unexpected result addr %h status %0d", $time, addr, st);
      errors++;
      return;
    end
    ea = exp_addr.pop_front();
    es = exp_st.pop_front();
    if (ea !== addr) begin
      $display("%0t: block_address expected %h actual %h", $time, ea, addr);
      errors++;
    end
    if (es !== st) begin
      $display("%0t: status expected %0d actual %0d", $time, es, st);
      errors++;
    end
  endfunction
endclass

module tb_best_fit_block_allocator_unit;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk_i = 0, rst_ni = 0;
  logic in_valid_i = 0, op_i = 0, out_stall_i = 0, cfg_valid_i = 0;
  logic [31:0] request_bytes_i = 0, type_mask_i = 0, free_address_i = 0, cfg_data_i = 0;
  logic [1:0] cfg_index_i = 0;
  logic in_stall_o, out_valid_o, cfg_ready_o;
  logic [31:0] block_address_o;
  logic [2:0] status_o;

  alloc_scoreboard sb = new();
  logic [31:0] live[$];

  best_fit_block_allocator_unit dut (.*);

  always begin
    #4 clk_i = 1;
    #4 clk_i = 0;
  end

  function automatic int rand_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) : $urandom_range(0, 2);
  endfunction

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) sb.check_result(block_address_o, status_o);
  end

  initial begin
    int g;
    forever begin
      @(posedge clk_i);
      if (g > 0) begin
        g--;
        out_stall_i <= 1;
      end else begin
        out_stall_i <= 0;
        if ($urandom_range(0, 7) == 0) g = rand_gap();
      end
    end
  end

  task automatic write_cfg(logic [1:0] idx, logic [31:0] v);
    do @(posedge clk_i); while (sb.exp_st.size() != 0);
    cfg_valid_i <= 1; cfg_index_i <= idx; cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    sb.write_reg(idx, v);
  endtask

  task automatic drain();
    while (sb.exp_st.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send(logic op, logic [31:0] req, logic [31:0] mask, logic [31:0] fa);
    repeat (1 + rand_gap()) @(posedge clk_i);
    in_valid_i <= 1; op_i <= op; request_bytes_i <= req;
    type_mask_i <= mask; free_address_i <= fa;
    do @(posedge clk_i); while (in_stall_o);
    in_valid_i <= 0;
    sb.note_item(op, req, mask, fa);
    if (op == bfa_pkg::OpAlloc && sb.exp_st[$] == bfa_pkg::StOk) live.push_back(sb.exp_addr[$]);
  endtask

  task automatic rand_item(logic [31:0] span);
    int k;
    k = $urandom_range(0, 99);
    if (k < 50) send(bfa_pkg::OpAlloc, $urandom_range(1, span), $urandom, $urandom);
    else if (k < 85 && live.size() > 0) begin
      int j;
      j = $urandom_range(0, live.size() - 1);
      send(bfa_pkg::OpFree, $urandom, $urandom, live[j]);
      live.delete(j);
    end else if (k < 92) send(bfa_pkg::OpAlloc, $urandom, $urandom, $urandom);
    else send(bfa_pkg::OpFree, $urandom, $urandom, $urandom);
  endtask

  initial begin
    #400000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    // directed: zero pool type, type mismatch, zero size, then small region
    send(bfa_pkg::OpAlloc, 4, 32'hFFFFFFFF, 0);
    write_cfg(bfa_pkg::CfgType, 32'h0000_0001);
    drain();
    send(bfa_pkg::OpAlloc, 4, 32'hFFFF_FFFE, 0);
    send(bfa_pkg::OpAlloc, 0, 32'hFFFFFFFF, 0);
    write_cfg(bfa_pkg::CfgBase, 32'h1000);
    write_cfg(bfa_pkg::CfgBytes, 32'h100);
    send(bfa_pkg::OpAlloc, 1, 1, 0);
    send(bfa_pkg::OpAlloc, 32'h40, 1, 0);
    send(bfa_pkg::OpAlloc, 5, 1, 0);
    send(bfa_pkg::OpFree, 0, 0, 32'h1004);
    send(bfa_pkg::OpAlloc, 4, 1, 0);
    send(bfa_pkg::OpFree, 0, 0, 32'h1004);
    send(bfa_pkg::OpAlloc, 32'hFFFFFFFF, 1, 0);
    send(bfa_pkg::OpAlloc, 32'hFFFFFFFD, 1, 0);
    send(bfa_pkg::OpAlloc, 32'h200, 1, 0);
    send(bfa_pkg::OpFree, 32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
    drain();
    // region wrapping past 2^32 and shrinking under live blocks
    write_cfg(bfa_pkg::CfgBase, 32'hFFFF_FF00);
    write_cfg(bfa_pkg::CfgBytes, 32'hFFFF_FFFF);
    write_cfg(bfa_pkg::CfgType, 32'hFFFF_FFFF);
    live.delete();
    send(bfa_pkg::OpAlloc, 32'h100, 32'h8000_0000, 0);
    send(bfa_pkg::OpAlloc, 4, 32'h8000_0000, 0);
    drain();
    write_cfg(bfa_pkg::CfgBytes, 32'h10);
    send(bfa_pkg::OpAlloc, 4, 1, 0);
    drain();
    // table full
    write_cfg(bfa_pkg::CfgBase, 0);
    write_cfg(bfa_pkg::CfgBytes, 32'hFFFF_FFFF);
    for (int i = 0; i < 140; i++) send(bfa_pkg::OpAlloc, $urandom_range(1, 64), 1, 0);
    for (int i = 0; i < 140; i++) send(bfa_pkg::OpFree, 0, 0, 32'hFFFF_FFFF);
    drain();
    // random phases; each phase starts from an emptied table
    for (int ph = 0; ph < 4; ph++) begin
      while (sb.starts.size() > 0) send(bfa_pkg::OpFree, 0, 0, sb.starts[0]);
      drain();
      live.delete();
      write_cfg(bfa_pkg::CfgBase, (ph == 3) ? 32'hFFFF_F000 : $urandom & 32'hFFFF_FFFC);
      write_cfg(bfa_pkg::CfgBytes, (ph == 1) ? 32'hFFFF_FFFF : $urandom_range(256, 8192));
      write_cfg(bfa_pkg::CfgType, $urandom | 32'h1);
      for (int i = 0; i < 200; i++) begin
        rand_item((ph == 1) ? 32'h10000 : 256);
        if (i == 100) drain();
      end
    end
    drain();
    if (sb.errors == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end
endmodule
`default_nettype wire

@@ filelist.f @@
src/bfa_pkg.sv
src/best_fit_block_allocator_unit.sv
src/bfa_checker.sv
dv/tb_best_fit_block_allocator_unit.sv
